[sv/abbc_pkg.sv]
// Package for the alpha bounding-box crop block: widths, register indexes
// and the result word layout. Used by every module of the block.
package abbc_pkg;

	// default coordinate width of the rectangle position counters
	localparam int COORD_BITS_DEF = 12;

	// fixed widths of the stream fields
	localparam int ALPHA_W = 8;
	localparam int CROP_W  = 13;

	// config port geometry: four 32-bit registers at byte offsets 0..12
	localparam int REG_ADDR_W = 4;
	localparam int REG_DATA_W = 32;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_RECT_X = 2'd0,
		REG_RECT_Y = 2'd1,
		REG_RECT_W = 2'd2,
		REG_RECT_H = 2'd3
	} reg_idx_t;

	// one crop result
	typedef struct packed {
		logic [CROP_W-1:0] crop_x;
		logic [CROP_W-1:0] crop_y;
		logic [CROP_W-1:0] crop_w;
		logic [CROP_W-1:0] crop_h;
		logic              all_transparent;
	} crop_res_t;

endpackage

[sv/abbc_cfg.sv]
// APB register file of the alpha bounding-box crop: rectangle position and size.
// Depends on abbc_pkg.
module abbc_cfg #(
	parameter int COORD_BITS = abbc_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [abbc_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [abbc_pkg::REG_DATA_W-1:0]  pwdata,
	output logic [abbc_pkg::REG_DATA_W-1:0]  prdata,
	output logic                             pready,
	output logic [COORD_BITS-1:0]            rect_x,
	output logic [COORD_BITS-1:0]            rect_y,
	output logic [COORD_BITS:0]              rect_w,
	output logic [COORD_BITS:0]              rect_h
);

	localparam int SW = COORD_BITS + 1;
	localparam int CW = (SW > abbc_pkg::CROP_W) ? SW : abbc_pkg::CROP_W;

	logic [COORD_BITS-1:0]        rect_x_q, rect_y_q;
	logic [SW-1:0]                rect_w_q, rect_h_q;
	logic                         wr_en;
	abbc_pkg::reg_idx_t           reg_idx;
	logic [abbc_pkg::CROP_W-1:0]  size_wr;
	logic [CW-1:0]                size_ext;
	logic [CW-1:0]                size_max;
	logic [SW-1:0]                size_new;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = abbc_pkg::reg_idx_t'(paddr[3:2]);

	// size write: keep low 13 bits, clamp to 2^COORD_BITS
	assign size_wr  = pwdata[abbc_pkg::CROP_W-1:0];
	assign size_ext = CW'(size_wr);
	assign size_max = CW'(1) << COORD_BITS;
	assign size_new = (size_ext > size_max) ? SW'(size_max) : SW'(size_ext);

	// register writes; a zero size is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_x_q <= '0;
			rect_y_q <= '0;
			rect_w_q <= SW'(1);
			rect_h_q <= SW'(1);
		end else if (wr_en) begin
			case (reg_idx)
				abbc_pkg::REG_RECT_X: rect_x_q <= pwdata[COORD_BITS-1:0];
				abbc_pkg::REG_RECT_Y: rect_y_q <= pwdata[COORD_BITS-1:0];
				abbc_pkg::REG_RECT_W: begin
					if (size_wr != '0) rect_w_q <= size_new;
				end
				abbc_pkg::REG_RECT_H: begin
					if (size_wr != '0) rect_h_q <= size_new;
				end
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			abbc_pkg::REG_RECT_X: prdata = abbc_pkg::REG_DATA_W'(rect_x_q);
			abbc_pkg::REG_RECT_Y: prdata = abbc_pkg::REG_DATA_W'(rect_y_q);
			abbc_pkg::REG_RECT_W: prdata = abbc_pkg::REG_DATA_W'(rect_w_q);
			abbc_pkg::REG_RECT_H: prdata = abbc_pkg::REG_DATA_W'(rect_h_q);
			default:              prdata = '0;
		endcase
	end

	assign rect_x = rect_x_q;
	assign rect_y = rect_y_q;
	assign rect_w = rect_w_q;
	assign rect_h = rect_h_q;

endmodule

[sv/abbc_track.sv]
// Position counters and running opaque bounds of the alpha bounding-box crop,
// plus the crop result of the current word. Depends on abbc_pkg.
module abbc_track #(
	parameter int COORD_BITS = abbc_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic [abbc_pkg::ALPHA_W-1:0]   pixel_alpha,
	input  logic                           is_last,
	input  logic [COORD_BITS-1:0]          rect_x,
	input  logic [COORD_BITS-1:0]          rect_y,
	input  logic [COORD_BITS:0]            rect_w,
	input  logic [COORD_BITS:0]            rect_h,
	output abbc_pkg::crop_res_t            res
);

	localparam int OW = abbc_pkg::CROP_W;
	localparam int AW = (COORD_BITS + 2 > OW) ? COORD_BITS + 2 : OW;

	logic [COORD_BITS-1:0] col_q, row_q;
	logic [COORD_BITS-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic                  seen_q;

	logic                  opaque;
	logic [COORD_BITS-1:0] min_col_n, max_col_n, min_row_n, max_row_n;
	logic                  seen_n;
	logic [COORD_BITS:0]   col_inc, row_inc;
	logic [COORD_BITS-1:0] col_n, row_n;
	logic [AW-1:0]         sum_x, sum_y, span_w, span_h;

	assign opaque = (pixel_alpha != '0);

	// bounds including this pixel
	always_comb begin
		min_col_n = min_col_q;
		max_col_n = max_col_q;
		min_row_n = min_row_q;
		max_row_n = max_row_q;
		if (opaque) begin
			if (!seen_q || col_q < min_col_q) min_col_n = col_q;
			if (!seen_q || col_q > max_col_q) max_col_n = col_q;
			if (!seen_q || row_q < min_row_q) min_row_n = row_q;
			if (!seen_q || row_q > max_row_q) max_row_n = row_q;
		end
		seen_n = seen_q || opaque;
	end

	// raster position advance with wrap at the rectangle edges
	assign col_inc = {1'b0, col_q} + (COORD_BITS+1)'(1);
	assign row_inc = {1'b0, row_q} + (COORD_BITS+1)'(1);
	always_comb begin
		if (col_inc >= rect_w) begin
			col_n = '0;
			row_n = (row_inc >= rect_h) ? '0 : row_inc[COORD_BITS-1:0];
		end else begin
			col_n = col_inc[COORD_BITS-1:0];
			row_n = row_q;
		end
	end

	// crop result; all-transparent gives the far corner and zero size
	always_comb begin
		if (seen_n) begin
			sum_x  = AW'(rect_x) + AW'(min_col_n);
			sum_y  = AW'(rect_y) + AW'(min_row_n);
			span_w = AW'(max_col_n) - AW'(min_col_n) + AW'(1);
			span_h = AW'(max_row_n) - AW'(min_row_n) + AW'(1);
		end else begin
			sum_x  = AW'(rect_x) + AW'(rect_w);
			sum_y  = AW'(rect_y) + AW'(rect_h);
			span_w = '0;
			span_h = '0;
		end
		res.crop_x          = sum_x[OW-1:0];
		res.crop_y          = sum_y[OW-1:0];
		res.crop_w          = span_w[OW-1:0];
		res.crop_h          = span_h[OW-1:0];
		res.all_transparent = !seen_n;
	end

	// state update; the last word of a rectangle clears everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '1;
			max_col_q <= '0;
			min_row_q <= '1;
			max_row_q <= '0;
			seen_q    <= 1'b0;
		end else if (adv) begin
			if (is_last) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= '1;
				max_col_q <= '0;
				min_row_q <= '1;
				max_row_q <= '0;
				seen_q    <= 1'b0;
			end else begin
				col_q     <= col_n;
				row_q     <= row_n;
				min_col_q <= min_col_n;
				max_col_q <= max_col_n;
				min_row_q <= min_row_n;
				max_row_q <= max_row_n;
				seen_q    <= seen_n;
			end
		end
	end

endmodule

[sv/alpha_bounding_box_crop.sv]
// Top level of the alpha bounding-box crop: input register, tracker, result
// register and APB config. Depends on abbc_pkg, abbc_cfg and abbc_track.
//
// Usage: set rect_x/rect_y/rect_w/rect_h over APB while the block is idle,
// then stream the rectangle's pixels in raster order on s_t*, one word per
// pixel, alpha byte in s_tdata and s_tlast on the final pixel. The block
// keeps its own column/row position and the opaque (alpha != 0) bounds.
// For each word with s_tlast one result word comes out on m_t*: the
// cropped rectangle in m_tdata and the all-transparent flag in m_tuser.
// Words without s_tlast produce no output.
// Throughput: one pixel per cycle unless a last pixel is held back (see Stall).
// Result path: the last pixel loads into the input register on acceptance, and
// the result register loads from it once stage 1 can advance.
// Stall: while a result waits in the output register, non-last pixels still
// flow; only the next last pixel waits in the input register, and s_tready
// drops once that register cannot move.
// Reset: position, bounds and both stages clear; registers return to
// x = y = 0, w = h = 1.
module alpha_bounding_box_crop #(
	parameter int COORD_BITS = abbc_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [abbc_pkg::REG_ADDR_W-1:0]      paddr,
	input  logic [abbc_pkg::REG_DATA_W-1:0]      pwdata,
	output logic [abbc_pkg::REG_DATA_W-1:0]      prdata,
	output logic                                 pready,
	// pixel stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,   // [7:0] pixel_alpha
	input  logic                                 s_tlast,   // is_last
	// crop result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [12:0] crop_x, [25:13] crop_y, [38:26] crop_w, [51:39] crop_h, [55:52] zero
	output logic [55:0]                          m_tdata,
	output logic [0:0]                           m_tuser    // [0] all_transparent
);

	logic [COORD_BITS-1:0]          rect_x, rect_y;
	logic [COORD_BITS:0]            rect_w, rect_h;

	logic                           valid_s1, last_s1;
	logic [abbc_pkg::ALPHA_W-1:0]   alpha_s1;
	logic                           valid_s2;
	abbc_pkg::crop_res_t            res_s2;
	abbc_pkg::crop_res_t            res_c;
	logic                           adv;

	abbc_cfg #(
		.COORD_BITS (COORD_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rect_x  (rect_x),
		.rect_y  (rect_y),
		.rect_w  (rect_w),
		.rect_h  (rect_h)
	);

	// stage 1 moves unless it holds a last word and the result slot is busy
	assign adv      = valid_s1 && (!last_s1 || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			alpha_s1 <= s_tdata;
			last_s1  <= s_tlast;
		end
	end

	abbc_track #(
		.COORD_BITS (COORD_BITS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.pixel_alpha (alpha_s1),
		.is_last     (last_s1),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_w      (rect_w),
		.rect_h      (rect_h),
		.res         (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_s2 <= res_c;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = {4'b0, res_s2.crop_h, res_s2.crop_w, res_s2.crop_y, res_s2.crop_x};
	assign m_tuser[0] = res_s2.all_transparent;

	// a new result only follows a last word leaving stage 1
	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(adv && last_s1))
		else $error("result appeared without a last pixel");

	// input stalls only behind a blocked last word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && valid_s2 && !m_tready))
		else $error("input stalled without cause");

	// an all-transparent result has zero size
	a_empty_size: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.all_transparent) |->
			(res_s2.crop_w == '0 && res_s2.crop_h == '0))
		else $error("transparent result with nonzero size");

endmodule
